@@ rtl/text_to_oled_byte_stream_unit_assert.svh @@
// Assertion macros shared by the text-to-OLED RTL.
`ifndef TEXT_TO_OLED_BYTE_STREAM_UNIT_ASSERT_SVH
`define TEXT_TO_OLED_BYTE_STREAM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TOBS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TOBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TOBS_ASSERT_IMPL(label, ante, cons, msg)
`define TOBS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/tobs_pkg.sv @@
`timescale 1ns / 1ps
package tobs_pkg;

  localparam int GLYPH_COLUMNS = 5;
  localparam int PAGE_COUNT    = 8;

  // configuration register indexes
  localparam logic [1:0] REG_START_PAGE = 2'd0;
  localparam logic [1:0] REG_CHAR_PITCH = 2'd1;
  localparam logic [1:0] REG_WRAP_LIMIT = 2'd2;

  localparam logic [2:0] START_PAGE_RST = 3'd2;
  localparam logic [6:0] CHAR_PITCH_RST = 7'd6;
  localparam logic [6:0] WRAP_LIMIT_RST = 7'd125;

  // command bases
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] BLANK_BYTE = 8'h00;

  // glyph rows of each character class
  localparam logic [5:0] ROW_COLON   = 6'd10;
  localparam logic [5:0] ROW_UPPER_A = 6'd11;
  localparam logic [5:0] ROW_LOWER_A = 6'd37;

  // byte slots within one character
  localparam logic [3:0] SLOT_PAGE   = 4'd0;
  localparam logic [3:0] SLOT_COL_LO = 4'd1;
  localparam logic [3:0] SLOT_COL_HI = 4'd2;
  localparam logic [3:0] SLOT_G0     = 4'd3;
  localparam logic [3:0] SLOT_G1     = 4'd4;
  localparam logic [3:0] SLOT_G2     = 4'd5;
  localparam logic [3:0] SLOT_G3     = 4'd6;
  localparam logic [3:0] SLOT_G4     = 4'd7;
  localparam logic [3:0] SLOT_BLANK  = 4'd8;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [2:0] start_page;
    logic [6:0] char_pitch;
    logic [6:0] wrap_limit;
  } cfg_t;

  // one classified character, as queued between front and back
  typedef struct packed {
    logic [2:0] page;
    logic [6:0] column;
    logic       glyph_ok;
    logic [5:0] row;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // 5x7 font, first column in the top byte
  function automatic logic [39:0] glyph_bits(input logic [5:0] row);
    logic [39:0] g;
    case (row)
      6'd0:  g = 40'h3E_51_49_45_3E;
      6'd1:  g = 40'h00_42_7F_40_00;
      6'd2:  g = 40'h42_61_51_49_46;
      6'd3:  g = 40'h21_41_45_4B_31;
      6'd4:  g = 40'h18_14_12_7F_10;
      6'd5:  g = 40'h27_45_45_45_39;
      6'd6:  g = 40'h3C_4A_49_49_30;
      6'd7:  g = 40'h01_71_09_05_03;
      6'd8:  g = 40'h36_49_49_49_36;
      6'd9:  g = 40'h06_49_49_29_1E;
      6'd10: g = 40'h00_36_36_00_00;
      6'd11: g = 40'h7E_11_11_11_7E;
      6'd12: g = 40'h7F_49_49_49_36;
      6'd13: g = 40'h3E_41_41_41_22;
      6'd14: g = 40'h7F_41_41_22_1C;
      6'd15: g = 40'h7F_49_49_49_41;
      6'd16: g = 40'h7F_09_09_09_01;
      6'd17: g = 40'h3E_41_49_49_7A;
      6'd18: g = 40'h7F_08_08_08_7F;
      6'd19: g = 40'h00_41_7F_41_00;
      6'd20: g = 40'h20_40_41_3F_01;
      6'd21: g = 40'h7F_08_14_22_41;
      6'd22: g = 40'h7F_40_40_40_40;
      6'd23: g = 40'h7F_02_0C_02_7F;
      6'd24: g = 40'h7F_04_08_10_7F;
      6'd25: g = 40'h3E_41_41_41_3E;
      6'd26: g = 40'h7F_09_09_09_06;
      6'd27: g = 40'h3E_41_51_21_5E;
      6'd28: g = 40'h7F_09_19_29_46;
      6'd29: g = 40'h46_49_49_49_31;
      6'd30: g = 40'h01_01_7F_01_01;
      6'd31: g = 40'h3F_40_40_40_3F;
      6'd32: g = 40'h1F_20_40_20_1F;
      6'd33: g = 40'h7F_20_18_20_7F;
      6'd34: g = 40'h63_14_08_14_63;
      6'd35: g = 40'h07_08_70_08_07;
      6'd36: g = 40'h61_51_49_45_43;
      6'd37: g = 40'h20_54_54_54_78;
      6'd38: g = 40'h7F_48_44_44_38;
      6'd39: g = 40'h38_44_44_44_20;
      6'd40: g = 40'h38_44_44_48_7F;
      6'd41: g = 40'h38_54_54_54_18;
      6'd42: g = 40'h08_7E_09_01_02;
      6'd43: g = 40'h0C_52_52_52_3E;
      6'd44: g = 40'h7F_08_04_04_78;
      6'd45: g = 40'h00_44_7D_40_00;
      6'd46: g = 40'h20_40_44_3D_00;
      6'd47: g = 40'h7F_10_28_44_00;
      6'd48: g = 40'h00_41_7F_40_00;
      6'd49: g = 40'h7C_04_18_04_78;
      6'd50: g = 40'h7C_08_04_04_78;
      6'd51: g = 40'h38_44_44_44_38;
      6'd52: g = 40'h7C_14_14_14_08;
      6'd53: g = 40'h08_14_14_18_7C;
      6'd54: g = 40'h7C_08_04_04_08;
      6'd55: g = 40'h48_54_54_54_20;
      6'd56: g = 40'h04_3F_44_40_20;
      6'd57: g = 40'h3C_40_40_20_7C;
      6'd58: g = 40'h1C_20_40_20_1C;
      6'd59: g = 40'h3C_40_30_40_3C;
      6'd60: g = 40'h44_28_10_28_44;
      6'd61: g = 40'h0C_50_50_50_3C;
      6'd62: g = 40'h44_64_54_4C_44;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/tobs_front.sv @@
`timescale 1ns / 1ps
module tobs_front (
  input  logic              clk,
  input  logic              rst,
  input  tobs_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  tobs_pkg::in_word_t in_word,
  input  tobs_pkg::q_stat_t q_stat,
  output logic              push,
  output tobs_pkg::job_t    job
);
  import tobs_pkg::*;

  logic [2:0] page;
  logic [6:0] column;
  logic [2:0] page_base;
  logic [6:0] col_base;
  logic [7:0] sum;
  logic       wrap;
  logic [7:0] code;
  logic       glyph_ok;
  logic [5:0] row;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign code     = in_word.char_code;

  always_comb begin
    page_base = in_word.first_of_string ? cfg.start_page : page;
    col_base  = in_word.first_of_string ? 7'd0 : column;
    sum       = {1'b0, col_base} + {1'b0, cfg.char_pitch};
    wrap      = sum >= {1'b0, cfg.wrap_limit};
  end

  // character classification
  always_comb begin
    glyph_ok = 1'b1;
    row      = 6'd0;
    priority if (code >= 8'h30 && code <= 8'h39) begin
      row = 6'(code - 8'h30);
    end else if (code == 8'h3A) begin
      row = ROW_COLON;
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      row = ROW_UPPER_A + 6'(code - 8'h41);
    end else if (code >= 8'h61 && code <= 8'h7A) begin
      row = ROW_LOWER_A + 6'(code - 8'h61);
    end else begin
      glyph_ok = 1'b0;
    end
  end

  assign job = '{page: page_base, column: col_base, glyph_ok: glyph_ok, row: row};

  always_ff @(posedge clk) begin
    if (rst) begin
      page   <= START_PAGE_RST;
      column <= 7'd0;
    end else if (push) begin
      page   <= wrap ? page_base + 3'd1 : page_base;
      column <= wrap ? 7'd0 : sum[6:0];
    end
  end

endmodule

@@ rtl/tobs_queue.sv @@
`timescale 1ns / 1ps
`include "text_to_oled_byte_stream_unit_assert.svh"
module tobs_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tobs_pkg::job_t    push_job,
  input  logic              pop,
  output tobs_pkg::job_t    head,
  output tobs_pkg::q_stat_t q_stat
);
  import tobs_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head   = slots[rd_ptr];
  assign q_stat = '{full: count == FULL_CNT, empty: count == '0};

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `TOBS_ASSERT_IMPL(a_no_overflow, push, !q_stat.full, "push into full queue")
  `TOBS_ASSERT_IMPL(a_no_underflow, pop, !q_stat.empty, "pop from empty queue")
  `TOBS_ASSERT_IMPL(a_count_range, 1'b1, count <= FULL_CNT, "queue count out of range")

endmodule

@@ rtl/tobs_back.sv @@
`timescale 1ns / 1ps
`include "text_to_oled_byte_stream_unit_assert.svh"
module tobs_back (
  input  logic                clk,
  input  logic                rst,
  input  tobs_pkg::job_t      head,
  input  tobs_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tobs_pkg::out_word_t out_word
);
  import tobs_pkg::*;

  logic [3:0]  slot;
  logic [39:0] gbits;
  logic [7:0]  byte_now;
  logic        data_now;
  logic        last_now;
  logic        load;

  assign gbits = glyph_bits(head.row);
  assign load  = !q_stat.empty && (!out_valid || out_ready);
  assign pop   = load && last_now;

  always_comb begin
    data_now = 1'b1;
    unique case (slot)
      SLOT_PAGE: begin
        byte_now = CMD_PAGE | {5'd0, head.page};
        data_now = 1'b0;
      end
      SLOT_COL_LO: begin
        byte_now = CMD_COL_LO | {4'd0, head.column[3:0]};
        data_now = 1'b0;
      end
      SLOT_COL_HI: begin
        byte_now = CMD_COL_HI | {5'd0, head.column[6:4]};
        data_now = 1'b0;
      end
      SLOT_G0: byte_now = gbits[39:32];
      SLOT_G1: byte_now = gbits[31:24];
      SLOT_G2: byte_now = gbits[23:16];
      SLOT_G3: byte_now = gbits[15:8];
      SLOT_G4: byte_now = gbits[7:0];
      default: byte_now = BLANK_BYTE;
    endcase
    last_now = head.glyph_ok ? (slot == SLOT_BLANK) : (slot == SLOT_COL_HI);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= '{out_byte: byte_now, is_data: data_now, last: last_now};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= SLOT_PAGE;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      slot      <= last_now ? SLOT_PAGE : slot + 4'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a part-sent character must stay at the queue head
  `TOBS_ASSERT_IMPL(a_head_held, slot != SLOT_PAGE, !q_stat.empty, "head lost mid character")
  `TOBS_ASSERT_IMPL(a_slot_range, 1'b1, slot <= SLOT_BLANK, "byte slot out of range")
  `TOBS_ASSERT_NEXT(a_last_ends, pop, slot == SLOT_PAGE, "slot not restarted after last word")

endmodule

@@ rtl/text_to_oled_byte_stream_unit.sv @@
// An accepted character is written into the queue, then its first word into the output register.
// One output word per cycle while the queue is not empty and out_ready is high; 9 words per
// supported character, 3 otherwise. Input is taken while the queue has room.
// Reset (synchronous, rst high): cursor to page 2 column 0, registers to start_page 2,
// char_pitch 6, wrap_limit 125; queue and output emptied.
`timescale 1ns / 1ps
module text_to_oled_byte_stream_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tobs_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tobs_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import tobs_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  job_t    push_job;
  job_t    head;
  logic    push;
  logic    pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_page <= START_PAGE_RST;
      cfg.char_pitch <= CHAR_PITCH_RST;
      cfg.wrap_limit <= WRAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_PAGE: cfg.start_page <= cfg_data[2:0];
        REG_CHAR_PITCH: cfg.char_pitch <= cfg_data;
        REG_WRAP_LIMIT: cfg.wrap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  tobs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  tobs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  tobs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
